// File: rtl/bpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and helpers for the barometer compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

    // datapath width of the compensation arithmetic
    localparam int DATA_W = 32;

    // configuration register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_AC1_AC2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AC3_AC4 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AC5_AC6 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B1_B2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MC_MD   = 3'd4;

    // compensation constants
    localparam logic [31:0] C_T_RND   = 32'd8;
    localparam logic [31:0] C_B6_OFS  = 32'd4000;
    localparam logic [31:0] C_B4_OFS  = 32'd32768;
    localparam logic [31:0] C_B7_MUL  = 32'd50000;
    localparam logic [31:0] C_P_MUL1  = 32'd3038;
    localparam logic [31:0] C_P_MUL2  = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] C_P_OFS   = 32'd3791;
    localparam logic [31:0] C_RND2    = 32'd2;
    localparam logic [19:0] C_P_MAX   = 20'hF_FFFF;
    localparam logic [15:0] C_T_MAX   = 16'h7FFF;
    localparam logic [15:0] C_T_MIN   = 16'h8000;

    // calibration coefficients, unpacked from the registers
    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mc;
        logic [15:0] md;
    } t_cal;

    // side data riding along the temperature divider
    typedef struct packed {
        logic [31:0] x1;
        logic        neg;
        logic        dz;
        logic [15:0] up;
    } t_tside;

    // side data riding along the pressure divider
    typedef struct packed {
        logic        hi;
        logic        bz;
        logic [15:0] tout;
        logic        terr;
    } t_pside;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // arithmetic right shift
    function automatic logic [31:0] sar(input logic [31:0] v, input int unsigned n);
        return $signed(v) >>> n;
    endfunction

    // signed division by 2^n, truncating toward zero
    function automatic logic [31:0] sdiv_pow2(input logic [31:0] a, input int unsigned n);
        logic [31:0] bias;
        bias = a[31] ? ((32'd1 << n) - 32'd1) : 32'd0;
        return $signed(a + bias) >>> n;
    endfunction

endpackage
`default_nettype wire

// File: rtl/bpc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with
// side data carried alongside each item.
// ----------------------------------------------------------------------------
module bpc_div #(
    parameter int SIDE_W = 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [bpc_pkg::DATA_W-1:0] i_dividend,
    input  wire logic [bpc_pkg::DATA_W-1:0] i_divisor,
    input  wire logic [SIDE_W-1:0]          i_side,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [bpc_pkg::DATA_W-1:0]      o_quot,
    output logic [SIDE_W-1:0]               o_side
);
    import bpc_pkg::*;

    localparam int NS = DATA_W;

    logic              r_v    [NS];
    logic [DATA_W-1:0] r_rem  [NS];
    logic [DATA_W-1:0] r_quo  [NS];
    logic [DATA_W-1:0] r_dsr  [NS];
    logic [SIDE_W-1:0] r_side [NS];
    logic [NS:0]       w_rdy;

    assign w_rdy[NS] = i_ready;
    assign o_ready   = w_rdy[0];
    assign o_valid   = r_v[NS-1];
    assign o_quot    = r_quo[NS-1];
    assign o_side    = r_side[NS-1];

    for (genvar k = 0; k < NS; k++) begin : g_st
        logic              w_v_in;
        logic [DATA_W-1:0] w_rem_in;
        logic [DATA_W-1:0] w_quo_in;
        logic [DATA_W-1:0] w_dsr_in;
        logic [SIDE_W-1:0] w_side_in;
        logic [DATA_W:0]   w_trial;
        logic [DATA_W:0]   w_diff;

        if (k == 0) begin : g_first
            assign w_v_in    = i_valid;
            assign w_rem_in  = '0;
            assign w_quo_in  = i_dividend;
            assign w_dsr_in  = i_divisor;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_v_in    = r_v[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_quo_in  = r_quo[k-1];
            assign w_dsr_in  = r_dsr[k-1];
            assign w_side_in = r_side[k-1];
        end

        // stage may load when empty or when its content moves on
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

        // shift in next dividend bit and try subtracting the divisor
        assign w_trial = {w_rem_in, w_quo_in[DATA_W-1]};
        assign w_diff  = w_trial - {1'b0, w_dsr_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_rem[k]  <= w_diff[DATA_W] ? w_trial[DATA_W-1:0] : w_diff[DATA_W-1:0];
                r_quo[k]  <= {w_quo_in[DATA_W-2:0], ~w_diff[DATA_W]};
                r_dsr[k]  <= w_dsr_in;
                r_side[k] <= w_side_in;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/bpc_tpre.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_tpre
// Temperature front end: X1 and the operands of the X2 division, as
// magnitudes with sign and zero-divisor flags.
// ----------------------------------------------------------------------------
module bpc_tpre (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [15:0]                i_raw_temp,
    input  wire logic [15:0]                i_raw_press,
    input  wire bpc_pkg::t_cal              i_cal,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [bpc_pkg::DATA_W-1:0]      o_dividend,
    output logic [bpc_pkg::DATA_W-1:0]      o_divisor,
    output bpc_pkg::t_tside                 o_side
);
    import bpc_pkg::*;

    logic [2:0]  r_v;
    logic [3:0]  w_rdy;
    logic [31:0] r_s1_prod;
    logic [15:0] r_s1_up;
    logic [31:0] r_s2_x1;
    logic [31:0] r_s2_den;
    logic [15:0] r_s2_up;
    logic [31:0] r_s3_dvd;
    logic [31:0] r_s3_dsr;
    t_tside      r_s3_side;
    logic [31:0] n_s2_x1;
    logic [31:0] n_s3_num;
    logic        n_s3_dz;

    // per-stage load enables
    assign w_rdy[3] = i_ready;
    assign w_rdy[2] = !r_v[2] || w_rdy[3];
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
        end
    end

    assign n_s2_x1  = sdiv_pow2(r_s1_prod, 15);
    assign n_s3_num = sext16(i_cal.mc) << 11;
    assign n_s3_dz  = (r_s2_den == 32'd0);

    // stage 1: (UT - AC6) * AC5
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s1_prod <= ({16'd0, i_raw_temp} - {16'd0, i_cal.ac6}) * {16'd0, i_cal.ac5};
            r_s1_up   <= i_raw_press;
        end
    end

    // stage 2: X1 and its divisor X1 + MD
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s2_x1  <= n_s2_x1;
            r_s2_den <= n_s2_x1 + sext16(i_cal.md);
            r_s2_up  <= r_s1_up;
        end
    end

    // stage 3: magnitudes and sign for the divider
    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_s3_dvd      <= n_s3_num[31] ? (32'd0 - n_s3_num) : n_s3_num;
            r_s3_dsr      <= n_s3_dz ? 32'd1
                           : (r_s2_den[31] ? (32'd0 - r_s2_den) : r_s2_den);
            r_s3_side.x1  <= r_s2_x1;
            r_s3_side.neg <= n_s3_num[31] ^ r_s2_den[31];
            r_s3_side.dz  <= n_s3_dz;
            r_s3_side.up  <= r_s2_up;
        end
    end

    assign o_valid    = r_v[2];
    assign o_dividend = r_s3_dvd;
    assign o_divisor  = r_s3_dsr;
    assign o_side     = r_s3_side;

endmodule
`default_nettype wire

// File: rtl/bpc_calc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_calc
// Middle section: B5, saturated temperature, B6, B3, B4 and B7, and the
// operands of the pressure division.
// ----------------------------------------------------------------------------
module bpc_calc (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [bpc_pkg::DATA_W-1:0] i_quot,
    input  wire bpc_pkg::t_tside            i_side,
    input  wire bpc_pkg::t_cal              i_cal,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [bpc_pkg::DATA_W-1:0]      o_dividend,
    output logic [bpc_pkg::DATA_W-1:0]      o_divisor,
    output bpc_pkg::t_pside                 o_side
);
    import bpc_pkg::*;

    logic [6:0]  r_v;
    logic [7:0]  w_rdy;

    logic [31:0] r_s1_b5;
    logic        r_s1_err;
    logic [15:0] r_s1_up;
    logic [31:0] r_s2_s;
    logic [31:0] r_s2_b6;
    logic        r_s2_err;
    logic [15:0] r_s2_up;
    logic [31:0] r_s3_m_bb;
    logic [31:0] r_s3_m_a2;
    logic [31:0] r_s3_m_a3;
    logic [15:0] r_s3_tout;
    logic        r_s3_err;
    logic [15:0] r_s3_up;
    logic [31:0] r_s4_m_sqb2;
    logic [31:0] r_s4_m_b1sq;
    logic [31:0] r_s4_x2p;
    logic [31:0] r_s4_x1b;
    logic [15:0] r_s4_tout;
    logic        r_s4_err;
    logic [15:0] r_s4_up;
    logic [31:0] r_s5_b3;
    logic [31:0] r_s5_x3;
    logic [15:0] r_s5_tout;
    logic        r_s5_err;
    logic [15:0] r_s5_up;
    logic [31:0] r_s6_m_b4;
    logic [31:0] r_s6_bdiff;
    logic [15:0] r_s6_tout;
    logic        r_s6_err;
    logic [31:0] r_s7_b4;
    logic [31:0] r_s7_b7;
    logic [15:0] r_s7_tout;
    logic        r_s7_err;

    logic [31:0] n_s1_x2;
    logic [31:0] n_s3_t;
    logic        n_s3_ok;
    logic [31:0] n_s4_sq;
    logic [31:0] n_s5_b3sum;
    logic [31:0] n_s5_x3sum;
    logic        n_bz;

    // per-stage load enables
    assign w_rdy[7] = i_ready;
    for (genvar k = 0; k < 7; k++) begin : g_rdy
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
    end
    assign o_ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            for (int k = 1; k < 7; k++) begin
                if (w_rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 1: signed X2 from the quotient, then B5
    assign n_s1_x2 = i_side.dz ? 32'd0 : (i_side.neg ? (32'd0 - i_quot) : i_quot);

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s1_b5  <= i_side.x1 + n_s1_x2;
            r_s1_err <= i_side.dz;
            r_s1_up  <= i_side.up;
        end
    end

    // stage 2: rounding sum for T and B6
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s2_s   <= r_s1_b5 + C_T_RND;
            r_s2_b6  <= r_s1_b5 - C_B6_OFS;
            r_s2_err <= r_s1_err;
            r_s2_up  <= r_s1_up;
        end
    end

    // stage 3: saturated T, products of B6
    assign n_s3_t  = sdiv_pow2(r_s2_s, 4);
    assign n_s3_ok = (&n_s3_t[31:15]) || !(|n_s3_t[31:15]);

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_s3_tout <= n_s3_ok ? n_s3_t[15:0] : (n_s3_t[31] ? C_T_MIN : C_T_MAX);
            r_s3_err  <= r_s2_err || !n_s3_ok;
            r_s3_m_bb <= r_s2_b6 * r_s2_b6;
            r_s3_m_a2 <= sext16(i_cal.ac2) * r_s2_b6;
            r_s3_m_a3 <= sext16(i_cal.ac3) * r_s2_b6;
            r_s3_up   <= r_s2_up;
        end
    end

    // stage 4: products of the scaled square
    assign n_s4_sq = sar(r_s3_m_bb, 12);

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_s4_m_sqb2 <= n_s4_sq * sext16(i_cal.b2);
            r_s4_m_b1sq <= sext16(i_cal.b1) * n_s4_sq;
            r_s4_x2p    <= sar(r_s3_m_a2, 11);
            r_s4_x1b    <= sar(r_s3_m_a3, 13);
            r_s4_tout   <= r_s3_tout;
            r_s4_err    <= r_s3_err;
            r_s4_up     <= r_s3_up;
        end
    end

    // stage 5: B3 and X3
    assign n_s5_b3sum = (sext16(i_cal.ac1) << 2) + sar(r_s4_m_sqb2, 11) + r_s4_x2p + C_RND2;
    assign n_s5_x3sum = r_s4_x1b + sar(r_s4_m_b1sq, 16) + C_RND2;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_s5_b3   <= sar(n_s5_b3sum, 2);
            r_s5_x3   <= sar(n_s5_x3sum, 2);
            r_s5_tout <= r_s4_tout;
            r_s5_err  <= r_s4_err;
            r_s5_up   <= r_s4_up;
        end
    end

    // stage 6: AC4 product and UP - B3
    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r_s6_m_b4  <= {16'd0, i_cal.ac4} * (r_s5_x3 + C_B4_OFS);
            r_s6_bdiff <= {16'd0, r_s5_up} - r_s5_b3;
            r_s6_tout  <= r_s5_tout;
            r_s6_err   <= r_s5_err;
        end
    end

    // stage 7: B4 and B7
    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            r_s7_b4   <= r_s6_m_b4 >> 15;
            r_s7_b7   <= r_s6_bdiff * C_B7_MUL;
            r_s7_tout <= r_s6_tout;
            r_s7_err  <= r_s6_err;
        end
    end

    // division order picked by the top bit of B7
    assign n_bz        = (r_s7_b4 == 32'd0);
    assign o_valid     = r_v[6];
    assign o_dividend  = r_s7_b7[31] ? r_s7_b7 : {r_s7_b7[30:0], 1'b0};
    assign o_divisor   = n_bz ? 32'd1 : r_s7_b4;
    assign o_side.hi   = r_s7_b7[31];
    assign o_side.bz   = n_bz;
    assign o_side.tout = r_s7_tout;
    assign o_side.terr = r_s7_err;

endmodule
`default_nettype wire

// File: rtl/bpc_post.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_post
// Pressure back end: final second-order correction, clamping and the
// output register.
// ----------------------------------------------------------------------------
module bpc_post (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [bpc_pkg::DATA_W-1:0] i_quot,
    input  wire bpc_pkg::t_pside            i_side,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic signed [15:0]              o_temp_decidegc,
    output logic [19:0]                     o_press_pa,
    output logic                            o_calc_error
);
    import bpc_pkg::*;

    logic [4:0]  r_v;
    logic [5:0]  w_rdy;

    logic [31:0] r_s1_p;
    logic [15:0] r_s1_tout;
    logic        r_s1_err;
    logic [31:0] r_s2_m_aa;
    logic [31:0] r_s2_m_p;
    logic [31:0] r_s2_p;
    logic [15:0] r_s2_tout;
    logic        r_s2_err;
    logic [31:0] r_s3_m3;
    logic [31:0] r_s3_x2;
    logic [31:0] r_s3_p;
    logic [15:0] r_s3_tout;
    logic        r_s3_err;
    logic [31:0] r_s4_pf;
    logic [15:0] r_s4_tout;
    logic        r_s4_err;
    logic [15:0] r_s5_tout;
    logic [19:0] r_s5_press;
    logic        r_s5_err;

    logic [31:0] n_s2_a;
    logic [31:0] n_s4_sum;
    logic        n_s5_hi;

    // per-stage load enables
    assign w_rdy[5] = i_ready;
    for (genvar k = 0; k < 5; k++) begin : g_rdy
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
    end
    assign o_ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            for (int k = 1; k < 5; k++) begin
                if (w_rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 1: raw pressure, undoing the division order
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s1_p    <= i_side.bz ? 32'd0 : (i_side.hi ? {i_quot[30:0], 1'b0} : i_quot);
            r_s1_tout <= i_side.tout;
            r_s1_err  <= i_side.terr || i_side.bz;
        end
    end

    // stage 2: square of P/256 and linear term
    assign n_s2_a = sar(r_s1_p, 8);

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s2_m_aa <= n_s2_a * n_s2_a;
            r_s2_m_p  <= r_s1_p * C_P_MUL2;
            r_s2_p    <= r_s1_p;
            r_s2_tout <= r_s1_tout;
            r_s2_err  <= r_s1_err;
        end
    end

    // stage 3: scale the square term
    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_s3_m3   <= r_s2_m_aa * C_P_MUL1;
            r_s3_x2   <= sar(r_s2_m_p, 16);
            r_s3_p    <= r_s2_p;
            r_s3_tout <= r_s2_tout;
            r_s3_err  <= r_s2_err;
        end
    end

    // stage 4: corrected pressure
    assign n_s4_sum = sar(r_s3_m3, 16) + r_s3_x2 + C_P_OFS;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_s4_pf   <= r_s3_p + sar(n_s4_sum, 4);
            r_s4_tout <= r_s3_tout;
            r_s4_err  <= r_s3_err;
        end
    end

    // stage 5: clamp into the output register
    assign n_s5_hi = |r_s4_pf[30:20];

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_s5_tout <= r_s4_tout;
            if (r_s4_pf[31]) begin
                r_s5_press <= 20'd0;
                r_s5_err   <= 1'b1;
            end else if (n_s5_hi) begin
                r_s5_press <= C_P_MAX;
                r_s5_err   <= 1'b1;
            end else begin
                r_s5_press <= r_s4_pf[19:0];
                r_s5_err   <= r_s4_err;
            end
        end
    end

    assign o_valid         = r_v[4];
    assign o_temp_decidegc = r_s5_tout;
    assign o_press_pa      = r_s5_press;
    assign o_calc_error    = r_s5_err;

`ifndef ASSERT_OFF
    // negative corrected pressure lands as zero with the flag
    a_neg_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[3] && w_rdy[4] && r_s4_pf[31]) |=> (o_press_pa == 20'd0 && o_calc_error))
        else $error("negative pressure not clamped to zero");

    // overrange pressure lands as full scale with the flag
    a_hi_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[3] && w_rdy[4] && !r_s4_pf[31] && n_s5_hi)
            |=> (o_press_pa == C_P_MAX && o_calc_error))
        else $error("overrange pressure not clamped to full scale");

    // an error raised upstream is never dropped
    a_err_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[3] && w_rdy[4] && r_s4_err) |=> o_calc_error)
        else $error("upstream error flag lost");
`endif

endmodule
`default_nettype wire

// File: rtl/barometer_temp_pressure_compensation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// barometer_temp_pressure_compensation
// Integer temperature and pressure compensation for a barometric sensor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) takes one beat holding a raw
//   temperature and raw pressure reading. Output channel (o_valid /
//   i_ready) gives temperature in 0.1 degC, pressure in Pa and an error
//   flag for each input beat, in order.
//   Calibration is written through the config channel (i_cfg_valid /
//   o_cfg_ready, always ready), register index plus 32-bit data; indexes
//   beyond the last register are ignored. Write only while no beat is
//   in flight.
//   The path runs through 3 temperature front-end stages, a 32-stage
//   divider for X2, 7 middle stages, a 32-stage divider for pressure
//   and 5 back-end stages ending in the output register. Each divider
//   stage resolves one quotient bit, which sets the depth. Throughput is
//   one beat per cycle unless the receiver stalls a full pipe. On a stall,
//   items pack into empty stages and o_ready falls only once the pipe is full.
//   Reset clears all stage valids and the calibration registers.
// ----------------------------------------------------------------------------
module barometer_temp_pressure_compensation (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [15:0]                    i_raw_temp,
    input  wire logic [15:0]                    i_raw_press,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic signed [15:0]                  o_temp_decidegc,
    output logic [19:0]                         o_press_pa,
    output logic                                o_calc_error,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [31:0]                    i_cfg_data
);
    import bpc_pkg::*;

    logic [31:0]       r_cal_ac1_ac2;
    logic [31:0]       r_cal_ac3_ac4;
    logic [31:0]       r_cal_ac5_ac6;
    logic [31:0]       r_cal_b1_b2;
    logic [31:0]       r_cal_mc_md;
    t_cal              w_cal;

    logic              w_tp_valid;
    logic              w_tp_ready;
    logic [DATA_W-1:0] w_tp_dvd;
    logic [DATA_W-1:0] w_tp_dsr;
    t_tside            w_tp_side;
    logic              w_td_valid;
    logic              w_td_ready;
    logic [DATA_W-1:0] w_td_quot;
    t_tside            w_td_side;
    logic              w_cc_valid;
    logic              w_cc_ready;
    logic [DATA_W-1:0] w_cc_dvd;
    logic [DATA_W-1:0] w_cc_dsr;
    t_pside            w_cc_side;
    logic              w_pd_valid;
    logic              w_pd_ready;
    logic [DATA_W-1:0] w_pd_quot;
    t_pside            w_pd_side;

    // configuration register writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_ac1_ac2 <= '0;
            r_cal_ac3_ac4 <= '0;
            r_cal_ac5_ac6 <= '0;
            r_cal_b1_b2   <= '0;
            r_cal_mc_md   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_AC1_AC2: r_cal_ac1_ac2 <= i_cfg_data;
                CFG_AC3_AC4: r_cal_ac3_ac4 <= i_cfg_data;
                CFG_AC5_AC6: r_cal_ac5_ac6 <= i_cfg_data;
                CFG_B1_B2:   r_cal_b1_b2   <= i_cfg_data;
                CFG_MC_MD:   r_cal_mc_md   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // unpack coefficients
    assign w_cal.ac1 = r_cal_ac1_ac2[31:16];
    assign w_cal.ac2 = r_cal_ac1_ac2[15:0];
    assign w_cal.ac3 = r_cal_ac3_ac4[31:16];
    assign w_cal.ac4 = r_cal_ac3_ac4[15:0];
    assign w_cal.ac5 = r_cal_ac5_ac6[31:16];
    assign w_cal.ac6 = r_cal_ac5_ac6[15:0];
    assign w_cal.b1  = r_cal_b1_b2[31:16];
    assign w_cal.b2  = r_cal_b1_b2[15:0];
    assign w_cal.mc  = r_cal_mc_md[31:16];
    assign w_cal.md  = r_cal_mc_md[15:0];

    // temperature front end
    bpc_tpre u_tpre (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_raw_temp  (i_raw_temp),
        .i_raw_press (i_raw_press),
        .i_cal       (w_cal),
        .o_valid     (w_tp_valid),
        .i_ready     (w_tp_ready),
        .o_dividend  (w_tp_dvd),
        .o_divisor   (w_tp_dsr),
        .o_side      (w_tp_side)
    );

    // X2 divider
    bpc_div #(
        .SIDE_W ($bits(t_tside))
    ) u_tdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_tp_valid),
        .o_ready    (w_tp_ready),
        .i_dividend (w_tp_dvd),
        .i_divisor  (w_tp_dsr),
        .i_side     (w_tp_side),
        .o_valid    (w_td_valid),
        .i_ready    (w_td_ready),
        .o_quot     (w_td_quot),
        .o_side     (w_td_side)
    );

    // temperature result and pressure coefficients
    bpc_calc u_calc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_td_valid),
        .o_ready    (w_td_ready),
        .i_quot     (w_td_quot),
        .i_side     (w_td_side),
        .i_cal      (w_cal),
        .o_valid    (w_cc_valid),
        .i_ready    (w_cc_ready),
        .o_dividend (w_cc_dvd),
        .o_divisor  (w_cc_dsr),
        .o_side     (w_cc_side)
    );

    // pressure divider
    bpc_div #(
        .SIDE_W ($bits(t_pside))
    ) u_pdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_cc_valid),
        .o_ready    (w_cc_ready),
        .i_dividend (w_cc_dvd),
        .i_divisor  (w_cc_dsr),
        .i_side     (w_cc_side),
        .o_valid    (w_pd_valid),
        .i_ready    (w_pd_ready),
        .o_quot     (w_pd_quot),
        .o_side     (w_pd_side)
    );

    // final correction and output register
    bpc_post u_post (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_pd_valid),
        .o_ready         (w_pd_ready),
        .i_quot          (w_pd_quot),
        .i_side          (w_pd_side),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_temp_decidegc (o_temp_decidegc),
        .o_press_pa      (o_press_pa),
        .o_calc_error    (o_calc_error)
    );

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the barometer compensation block: directed table
// of readings and calibration sets, then random beats, checked in order
// against an in-bench integer compensation model.
// ----------------------------------------------------------------------------
module tb;
    import bpc_pkg::*;

    localparam int PIPE_LAT = 79;

    typedef struct {
        logic [15:0] temp;
        logic [19:0] press;
        logic        err;
    } comp_t;

    typedef struct {
        logic [15:0] ut;
        logic [15:0] up;
        logic        known;
        comp_t       res;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [15:0] i_raw_temp = '0;
    logic [15:0] i_raw_press = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [15:0] o_temp_decidegc;
    logic [19:0] o_press_pa;
    logic o_calc_error;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    logic [31:0] cal_regs [0:4];
    comp_t expected_q [$];
    int n_fail = 0;
    int rx_hold = 0;
    bit rx_run = 1'b0;

    barometer_temp_pressure_compensation DUT (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

    // signed divide, truncating toward zero
    function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] asr(logic [31:0] v, int n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [31:0] s16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // integer compensation of one reading pair
    function automatic comp_t compensate(logic [15:0] ut16, logic [15:0] up16);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, b5, t, b6, sq, b3, b4, b7, p;
        comp_t r;
        ac1 = s16(cal_regs[0][31:16]); ac2 = s16(cal_regs[0][15:0]);
        ac3 = s16(cal_regs[1][31:16]); ac4 = {16'd0, cal_regs[1][15:0]};
        ac5 = {16'd0, cal_regs[2][31:16]}; ac6 = {16'd0, cal_regs[2][15:0]};
        b1 = s16(cal_regs[3][31:16]); b2 = s16(cal_regs[3][15:0]);
        mc = s16(cal_regs[4][31:16]); md = s16(cal_regs[4][15:0]);
        r.err = 1'b0;
        x1 = div_trunc(({16'd0, ut16} - ac6) * ac5, 32'd32768);
        if (x1 + md == 32'd0) begin
            x2 = 0;
            r.err = 1'b1;
        end else begin
            x2 = div_trunc(mc * 32'd2048, x1 + md);
        end
        b5 = x1 + x2;
        t = div_trunc(b5 + 32'd8, 32'd16);
        if (t + 32'h8000 <= 32'hFFFF) begin
            r.temp = t[15:0];
        end else begin
            r.err = 1'b1;
            r.temp = t[31] ? 16'h8000 : 16'h7FFF;
        end
        b6 = b5 - 32'd4000;
        sq = asr(b6 * b6, 12);
        x1 = asr(sq * b2, 11);
        x2 = asr(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = asr(ac1 * 32'd4 + x3 + 32'd2, 2);
        x1 = asr(ac3 * b6, 13);
        x2 = asr(b1 * sq, 16);
        x3 = asr(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        b7 = ({16'd0, up16} - b3) * 32'd50000;
        if (b4 == 0) begin
            p = 0;
            r.err = 1'b1;
        end else if (!b7[31]) begin
            p = (b7 << 1) / b4;
        end else begin
            p = (b7 / b4) << 1;
        end
        x1 = asr(p, 8);
        x1 = x1 * x1;
        x1 = asr(x1 * 32'd3038, 16);
        x2 = asr(p * 32'hFFFF_E343, 16);
        p = p + asr(x1 + x2 + 32'd3791, 4);
        if (p[31]) begin
            r.press = 0;
            r.err = 1'b1;
        end else if (p > 32'd1048575) begin
            r.press = 20'hF_FFFF;
            r.err = 1'b1;
        end else begin
            r.press = p[19:0];
        end
        return r;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    // one calibration write, block idle
    task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= CFG_MC_MD) cal_regs[idx] = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_cal(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            logic [31:0] d, logic [31:0] e);
        write_cal(CFG_AC1_AC2, a);
        write_cal(CFG_AC3_AC4, b);
        write_cal(CFG_AC5_AC6, c);
        write_cal(CFG_B1_B2, d);
        write_cal(CFG_MC_MD, e);
    endtask

    // send one beat, optionally with a hand-typed expectation
    task automatic send_beat(logic [15:0] ut, logic [15:0] up, bit known, comp_t res,
                             bit idle_ok);
        comp_t e;
        int g;
        g = idle_ok ? gap_len() : 0;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_raw_temp <= ut;
        i_raw_press <= up;
        e = compensate(ut, up);
        if (known && (e.temp != res.temp || e.press != res.press || e.err != res.err))
            $error("table row disagrees with model for ut=%h up=%h", ut, up);
        expected_q.push_back(known ? res : e);
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 5) @(posedge i_clk);
    endtask

    // receiver: random stalls, in-order compare
    always @(posedge i_clk) begin
        comp_t e;
        if (rx_run) begin
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result beat");
                    n_fail++;
                end else begin
                    e = expected_q.pop_front();
                    if (o_temp_decidegc !== e.temp) begin
                        $error("temp_decidegc exp %h got %h", e.temp, o_temp_decidegc);
                        n_fail++;
                    end
                    if (o_press_pa !== e.press) begin
                        $error("press_pa exp %h got %h", e.press, o_press_pa);
                        n_fail++;
                    end
                    if (o_calc_error !== e.err) begin
                        $error("calc_error exp %b got %b", e.err, o_calc_error);
                        n_fail++;
                    end
                end
            end
            // stall runs of random length, mostly short
            if (rx_hold > 0) begin
                rx_hold--;
                i_ready <= 1'b0;
            end else begin
                rx_hold = gap_len();
                i_ready <= (rx_hold == 0);
            end
        end
    end

    stim_row_t rows [$];
    comp_t zres;

    initial begin
        int seg;
        stim_row_t row;
        for (int i = 0; i < 5; i++) cal_regs[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rx_run = 1'b1;
        @(posedge i_clk);

        // after reset all coefficients are zero: zero divisors, flagged,
        // pressure is only the final offset term
        zres = compensate(16'h0000, 16'h0000);
        row = '{16'h0000, 16'h0000, 1'b1, '{16'h0000, 20'd236, 1'b1}};
        rows.push_back(row);
        row = '{16'hFFFF, 16'hFFFF, 1'b1, '{16'h0000, 20'd236, 1'b1}};
        rows.push_back(row);
        row = '{16'h8000, 16'h7FFF, 1'b1, '{16'h0000, 20'd236, 1'b1}};
        rows.push_back(row);
        foreach (rows[i]) send_beat(rows[i].ut, rows[i].up, rows[i].known, rows[i].res, 1'b0);
        drain();

        // typical datasheet coefficients plus edges
        load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
                 {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
        rows.delete();
        rows.push_back('{16'd27898, 16'd23843, 1'b0, zres});
        rows.push_back('{16'h0000, 16'h0000, 1'b0, zres});
        rows.push_back('{16'hFFFF, 16'hFFFF, 1'b0, zres});
        rows.push_back('{16'h5555, 16'hAAAA, 1'b0, zres});
        rows.push_back('{16'hAAAA, 16'h5555, 1'b0, zres});
        rows.push_back('{16'd23153, 16'd40000, 1'b0, zres});
        foreach (rows[i]) send_beat(rows[i].ut, rows[i].up, 1'b0, zres, 1'b1);
        drain();

        // extreme coefficients: saturation, zero temperature divisor
        load_cal(32'h7FFF_8000, 32'h8000_FFFF, 32'hFFFF_0000, 32'h7FFF_8000, 32'h8000_0000);
        write_cal(3'd7, 32'hDEAD_BEEF);
        for (int i = 0; i < 6; i++)
            send_beat(i[0] ? 16'hFFFF : 16'h0000, i[1] ? 16'hFFFF : 16'h0000, 1'b0, zres, 1'b1);
        drain();
        // md is zero and x1 is zero at these small ut -> zero divisor
        load_cal(32'h0001_0001, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000);
        send_beat(16'h0000, 16'h1234, 1'b0, zres, 1'b1);
        send_beat(16'h0001, 16'hFFFF, 1'b0, zres, 1'b1);
        drain();

        // random phases with fresh calibration
        for (seg = 0; seg < 8; seg++) begin
            if (seg % 2 == 0)
                load_cal({16'd408 + 16'($urandom_range(0, 200)), -16'sd72},
                         {-16'sd14383, 16'd30000 + 16'($urandom_range(0, 5000))},
                         {16'd32757, 16'd23153}, {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
            else
                load_cal($urandom, $urandom, $urandom, $urandom, $urandom);
            for (int k = 0; k < 100; k++) begin
                if (seg % 2 == 0)
                    send_beat(16'd20000 + 16'($urandom_range(0, 15000)),
                              16'd15000 + 16'($urandom_range(0, 30000)), 1'b0, zres, 1'b1);
                else
                    send_beat(16'($urandom), 16'($urandom), 1'b0, zres, 1'b1);
            end
            drain();
        end

        if (n_fail == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// File: sim.f
rtl/bpc_pkg.sv
rtl/bpc_div.sv
rtl/bpc_tpre.sv
rtl/bpc_calc.sv
rtl/bpc_post.sv
rtl/barometer_temp_pressure_compensation.sv
tb/tb.sv
